FILE: src/qrv_pkg.sv
// Shared types, widths and helpers for the quaternion vector rotation pipeline.
// No dependencies; every other file in src imports this package.
package qrv_pkg;

  // Fixed-point format of the quaternion and of the results.
  localparam int FRAC_BITS = 14;

  // Port and datapath widths.
  localparam int QW     = 16;                    // input and output fields
  localparam int PW     = 2 * QW + 1;            // components of q * v
  localparam int TW     = PW + QW + 1;           // rotated components, exact
  localparam int RND_SH = 2 * FRAC_BITS - 2;     // exact scale down to output scale
  localparam int MW     = TW - RND_SH;           // rounded magnitude
  localparam int SQW    = 2 * MW + 2;            // sum of three rounded squares
  localparam int NW     = 31;                    // normalized magnitude
  localparam int NTOP   = NW - 1;                // target top bit after normalizing
  localparam int SHW    = 5;                     // normalizing shift amount
  localparam int MSBW   = 5;                     // index of the top set bit
  localparam int XW     = 2 * NW + 2;            // sum of normalized squares
  localparam int LW     = XW / 2;                // square root width
  localparam int RW     = LW + 3;                // square root remainder
  localparam int QBITS  = FRAC_BITS + 1;         // quotient bits
  localparam int DW     = NW + FRAC_BITS + 1;    // division remainder
  localparam int TOLW   = 15;                    // tolerance register

  localparam logic [TOLW-1:0] TOL_RESET = TOLW'(2);
  localparam int OUT_MAX = ((1 << FRAC_BITS) > 32767) ? 32767 : (1 << FRAC_BITS);

  // Per-item side information carried alongside the square root and divider.
  typedef struct packed {
    logic [2:0][MW-1:0] mag;   // rounded magnitudes
    logic [2:0][NW-1:0] nrm;   // normalized magnitudes
    logic [2:0]         neg;   // component signs
    logic               zero;  // all rounded components are zero
    logic               pass;  // squared length within tolerance of one
  } qrv_side_t;

  // Saturate a magnitude to the output range and apply the sign.
  function automatic logic [QW-1:0] sat_pack(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] m;
    m = (mag > MW'(OUT_MAX)) ? MW'(OUT_MAX) : mag;
    return neg ? (~QW'(m) + QW'(1)) : QW'(m);
  endfunction

endpackage

FILE: src/qrv_rotate.sv
// Two pipelined Hamilton products forming the vector part of q * v * conj(q).
// Depends on qrv_pkg. Four register stages, all advancing on adv.
module qrv_rotate
  import qrv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  input  logic signed [QW-1:0] vec_x,
  input  logic signed [QW-1:0] vec_y,
  input  logic signed [QW-1:0] vec_z,
  output logic                 t_valid,
  output logic signed [TW-1:0] t_out [3]
);

  logic [3:0] valid_r;

  logic signed [QW-1:0]   q1_r  [4];
  logic signed [QW-1:0]   q2_r  [4];
  logic signed [2*QW-1:0] pa_r  [12];
  logic signed [2*QW-1:0] pa_nxt[12];
  logic signed [PW-1:0]   p_r   [4];
  logic signed [PW-1:0]   p_nxt [4];
  logic signed [PW+QW-1:0] pb_r  [12];
  logic signed [PW+QW-1:0] pb_nxt[12];
  logic signed [TW-1:0]   t_r   [3];
  logic signed [TW-1:0]   t_nxt [3];

  // First product: quaternion times pure vector, partial products.
  always_comb begin
    pa_nxt[0]  = quat_w * vec_x;
    pa_nxt[1]  = quat_y * vec_z;
    pa_nxt[2]  = quat_z * vec_y;
    pa_nxt[3]  = quat_w * vec_y;
    pa_nxt[4]  = quat_z * vec_x;
    pa_nxt[5]  = quat_x * vec_z;
    pa_nxt[6]  = quat_w * vec_z;
    pa_nxt[7]  = quat_x * vec_y;
    pa_nxt[8]  = quat_y * vec_x;
    pa_nxt[9]  = quat_x * vec_x;
    pa_nxt[10] = quat_y * vec_y;
    pa_nxt[11] = quat_z * vec_z;
  end

  // Sum into the components of p, ordered x, y, z, real.
  always_comb begin
    p_nxt[0] = PW'(pa_r[0]) + PW'(pa_r[1]) - PW'(pa_r[2]);
    p_nxt[1] = PW'(pa_r[3]) + PW'(pa_r[4]) - PW'(pa_r[5]);
    p_nxt[2] = PW'(pa_r[6]) + PW'(pa_r[7]) - PW'(pa_r[8]);
    p_nxt[3] = -PW'(pa_r[9]) - PW'(pa_r[10]) - PW'(pa_r[11]);
  end

  // Second product: p times the conjugate, partial products.
  always_comb begin
    pb_nxt[0]  = p_r[3] * q2_r[1];
    pb_nxt[1]  = p_r[0] * q2_r[0];
    pb_nxt[2]  = p_r[1] * q2_r[3];
    pb_nxt[3]  = p_r[2] * q2_r[2];
    pb_nxt[4]  = p_r[3] * q2_r[2];
    pb_nxt[5]  = p_r[1] * q2_r[0];
    pb_nxt[6]  = p_r[2] * q2_r[1];
    pb_nxt[7]  = p_r[0] * q2_r[3];
    pb_nxt[8]  = p_r[3] * q2_r[3];
    pb_nxt[9]  = p_r[2] * q2_r[0];
    pb_nxt[10] = p_r[0] * q2_r[2];
    pb_nxt[11] = p_r[1] * q2_r[1];
  end

  // Sum into the rotated vector components.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_nxt[i] = -TW'(pb_r[4*i]) + TW'(pb_r[4*i+1]) - TW'(pb_r[4*i+2])
                 + TW'(pb_r[4*i+3]);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r[0] <= quat_w;
      q1_r[1] <= quat_x;
      q1_r[2] <= quat_y;
      q1_r[3] <= quat_z;
      q2_r    <= q1_r;
      pa_r    <= pa_nxt;
      p_r     <= p_nxt;
      pb_r    <= pb_nxt;
      t_r     <= t_nxt;
    end
  end

  assign t_valid = valid_r[3];
  assign t_out   = t_r;

endmodule

FILE: src/qrv_prep.sv
// Rounding, zero and tolerance checks, normalizing shift and squared length.
// Depends on qrv_pkg. Six register stages, all advancing on adv.
module qrv_prep
  import qrv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 t_valid,
  input  logic signed [TW-1:0] t_in [3],
  input  logic [TOLW-1:0]      tol,
  output logic                 x_valid,
  output logic [XW-1:0]        x_out,
  output qrv_side_t            side_out
);

  logic [5:0] valid_r;

  // Stage 5: rounded magnitudes.
  logic [MW-1:0]  m5_r  [3];
  logic [MW-1:0]  m5_nxt[3];
  logic [2:0]     neg5_r;
  logic [2:0]     neg5_nxt;
  // Stage 6: squares and OR word.
  logic [2*MW-1:0] sq6_r [3];
  logic [MW-1:0]   or6_r;
  logic [MW-1:0]   m6_r  [3];
  logic [2:0]      neg6_r;
  // Stage 7: squared length and shift amount.
  logic [SQW-1:0]  sum7_r;
  logic [SQW-1:0]  sum7_nxt;
  logic [SHW-1:0]  sh7_r;
  logic [SHW-1:0]  sh7_nxt;
  logic            zero7_r;
  logic [MW-1:0]   m7_r  [3];
  logic [2:0]      neg7_r;
  // Stage 8 onward: side struct.
  qrv_side_t       side8_r;
  qrv_side_t       side8_nxt;
  qrv_side_t       side9_r;
  qrv_side_t       side10_r;
  logic [2*NW-1:0] nsq9_r [3];
  logic [XW-1:0]   x10_r;

  // Magnitude and round to nearest, ties away from zero.
  always_comb begin
    logic [TW-1:0] mag;
    logic [TW-1:0] rnd;
    for (int i = 0; i < 3; i++) begin
      neg5_nxt[i] = t_in[i][TW-1];
      mag         = neg5_nxt[i] ? (~t_in[i] + TW'(1)) : t_in[i];
      rnd         = mag + (TW'(1) << (RND_SH - 1));
      m5_nxt[i]   = MW'(rnd >> RND_SH);
    end
  end

  // Squared length and position of the top set bit of the largest magnitude.
  always_comb begin
    logic [MSBW-1:0] msb;
    msb = '0;
    for (int b = 0; b < MW; b++) begin
      if (or6_r[b]) begin
        msb = MSBW'(b);
      end
    end
    sh7_nxt  = SHW'(NTOP) - SHW'(msb);
    sum7_nxt = SQW'(sq6_r[0]) + SQW'(sq6_r[1]) + SQW'(sq6_r[2]);
  end

  // Tolerance test and normalizing shift.
  always_comb begin
    logic [SQW-1:0] one;
    logic [SQW-1:0] diff;
    one  = SQW'(1) << (2 * FRAC_BITS);
    diff = (sum7_r > one) ? (sum7_r - one) : (one - sum7_r);
    side8_nxt.pass = (diff <= (SQW'(tol) << FRAC_BITS));
    side8_nxt.zero = zero7_r;
    side8_nxt.neg  = neg7_r;
    for (int i = 0; i < 3; i++) begin
      side8_nxt.mag[i] = m7_r[i];
      side8_nxt.nrm[i] = NW'(m7_r[i]) << sh7_r;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[4:0], t_valid};
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      m5_r    <= m5_nxt;
      neg5_r  <= neg5_nxt;
      for (int i = 0; i < 3; i++) begin
        sq6_r[i]  <= m5_r[i] * m5_r[i];
        nsq9_r[i] <= side8_r.nrm[i] * side8_r.nrm[i];
      end
      or6_r    <= m5_r[0] | m5_r[1] | m5_r[2];
      m6_r     <= m5_r;
      neg6_r   <= neg5_r;
      sum7_r   <= sum7_nxt;
      sh7_r    <= sh7_nxt;
      zero7_r  <= (or6_r == '0);
      m7_r     <= m6_r;
      neg7_r   <= neg6_r;
      side8_r  <= side8_nxt;
      side9_r  <= side8_r;
      side10_r <= side9_r;
      x10_r    <= XW'(nsq9_r[0]) + XW'(nsq9_r[1]) + XW'(nsq9_r[2]);
    end
  end

  assign x_valid  = valid_r[5];
  assign x_out    = x10_r;
  assign side_out = side10_r;

endmodule

FILE: src/qrv_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on qrv_pkg. LW stages, all advancing on adv.
module qrv_isqrt
  import qrv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            x_valid,
  input  logic [XW-1:0]   x_in,
  input  qrv_side_t       side_in,
  output logic            len_valid,
  output logic [LW-1:0]   len_out,
  output qrv_side_t       side_out
);

  logic [LW-1:0] valid_r;
  logic [LW-1:0] root_r [LW];
  logic [RW-1:0] rem_r  [LW];
  logic [XW-1:0] xs_r   [LW];
  qrv_side_t     side_r [LW];

  for (genvar k = 0; k < LW; k++) begin : g_stage
    logic          valid_in;
    logic [LW-1:0] root_in;
    logic [RW-1:0] rem_in;
    logic [XW-1:0] xs_in;
    qrv_side_t     side_in_k;
    logic [RW-1:0] acc;
    logic [RW-1:0] trial;
    logic [LW-1:0] root_nxt;
    logic [RW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign valid_in  = x_valid;
      assign root_in   = '0;
      assign rem_in    = '0;
      assign xs_in     = x_in;
      assign side_in_k = side_in;
    end else begin : g_next
      assign valid_in  = valid_r[k-1];
      assign root_in   = root_r[k-1];
      assign rem_in    = rem_r[k-1];
      assign xs_in     = xs_r[k-1];
      assign side_in_k = side_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      acc   = {rem_in[RW-3:0], xs_in[XW-1 -: 2]};
      trial = RW'({root_in, 2'b01});
      if (acc >= trial) begin
        rem_nxt  = acc - trial;
        root_nxt = {root_in[LW-2:0], 1'b1};
      end else begin
        rem_nxt  = acc;
        root_nxt = {root_in[LW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[k] <= root_nxt;
        rem_r[k]  <= rem_nxt;
        xs_r[k]   <= xs_in << 2;
        side_r[k] <= side_in_k;
      end
    end
  end

  assign len_valid = valid_r[LW-1];
  assign len_out   = root_r[LW-1];
  assign side_out  = side_r[LW-1];

endmodule

FILE: src/qrv_divide.sv
// Pipelined restoring division of each normalized magnitude by the length.
// Depends on qrv_pkg. One numerator stage, then one quotient bit per stage.
module qrv_divide
  import qrv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               len_valid,
  input  logic [LW-1:0]      len_in,
  input  qrv_side_t          side_in,
  output logic               q_valid,
  output logic [QBITS-1:0]   quot_out [3],
  output qrv_side_t          side_out
);

  localparam int NS = QBITS + 1;

  logic [NS-1:0]    valid_r;
  logic [DW-1:0]    rem_r  [NS][3];
  logic [QBITS-1:0] quot_r [NS][3];
  logic [LW-1:0]    len_r  [NS];
  qrv_side_t        side_r [NS];

  // Numerator with the rounding half of the divisor added in.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i]  <= (DW'(side_in.nrm[i]) << FRAC_BITS) + DW'(len_in >> 1);
        quot_r[0][i] <= '0;
      end
      len_r[0]  <= len_in;
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    localparam int BIT = QBITS - k;
    logic [DW-1:0]    den;
    logic [DW-1:0]    rem_nxt  [3];
    logic [QBITS-1:0] quot_nxt [3];

    // One quotient bit for each lane.
    always_comb begin
      den = DW'(len_r[k-1]) << BIT;
      for (int i = 0; i < 3; i++) begin
        quot_nxt[i] = quot_r[k-1][i];
        if (rem_r[k-1][i] >= den) begin
          rem_nxt[i]       = rem_r[k-1][i] - den;
          quot_nxt[i][BIT] = 1'b1;
        end else begin
          rem_nxt[i] = rem_r[k-1][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        quot_r[k] <= quot_nxt;
        len_r[k]  <= len_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NS-2:0], len_valid};
    end
  end

  assign q_valid  = valid_r[NS-1];
  assign quot_out = quot_r[NS-1];
  assign side_out = side_r[NS-1];

endmodule

FILE: src/quaternion_rotate_vector.sv
// Rotates a Q3.12 vector by a Q1.14 quaternion and renormalizes the result.
// Throughput: one transaction per cycle; a stalled output freezes the whole
// pipeline, so in_stall follows out_stall while a result is held.
// Reset (rst_n low, synchronous) empties the pipeline and sets unit_tolerance to 2.
// Depends on qrv_pkg, qrv_rotate, qrv_prep, qrv_isqrt and qrv_divide.
module quaternion_rotate_vector
  import qrv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [QW-1:0] in_quat_w,
  input  logic signed [QW-1:0] in_quat_x,
  input  logic signed [QW-1:0] in_quat_y,
  input  logic signed [QW-1:0] in_quat_z,
  input  logic signed [QW-1:0] in_vec_x,
  input  logic signed [QW-1:0] in_vec_y,
  input  logic signed [QW-1:0] in_vec_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [QW-1:0] out_x,
  output logic signed [QW-1:0] out_y,
  output logic signed [QW-1:0] out_z,
  output logic                 out_zero_length,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TOLW-1:0]      cfg_unit_tolerance
);

  logic                 adv;
  logic [TOLW-1:0]      tol_r;
  logic                 t_valid;
  logic signed [TW-1:0] t_val [3];
  logic                 x_valid;
  logic [XW-1:0]        x_val;
  qrv_side_t            side_x;
  logic                 len_valid;
  logic [LW-1:0]        len_val;
  qrv_side_t            side_len;
  logic                 q_valid;
  logic [QBITS-1:0]     quot [3];
  qrv_side_t            side_q;
  logic                 out_valid_r;
  logic [QW-1:0]        out_r     [3];
  logic [QW-1:0]        out_nxt   [3];
  logic                 zero_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Tolerance register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_unit_tolerance;
    end
  end

  qrv_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_valid(in_valid),
    .quat_w  (in_quat_w),
    .quat_x  (in_quat_x),
    .quat_y  (in_quat_y),
    .quat_z  (in_quat_z),
    .vec_x   (in_vec_x),
    .vec_y   (in_vec_y),
    .vec_z   (in_vec_z),
    .t_valid (t_valid),
    .t_out   (t_val)
  );

  qrv_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .t_valid (t_valid),
    .t_in    (t_val),
    .tol     (tol_r),
    .x_valid (x_valid),
    .x_out   (x_val),
    .side_out(side_x)
  );

  qrv_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .x_valid  (x_valid),
    .x_in     (x_val),
    .side_in  (side_x),
    .len_valid(len_valid),
    .len_out  (len_val),
    .side_out (side_len)
  );

  qrv_divide u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .len_valid(len_valid),
    .len_in   (len_val),
    .side_in  (side_len),
    .q_valid  (q_valid),
    .quot_out (quot),
    .side_out (side_q)
  );

  // Pick the zero, pass-through or divided result and saturate.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_q.zero) begin
        out_nxt[i] = '0;
      end else if (side_q.pass) begin
        out_nxt[i] = sat_pack(side_q.neg[i], side_q.mag[i]);
      end else begin
        out_nxt[i] = sat_pack(side_q.neg[i], MW'(quot[i]));
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r  <= out_nxt;
      zero_r <= side_q.zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_r[0];
  assign out_y           = out_r[1];
  assign out_z           = out_r[2];
  assign out_zero_length = zero_r;

endmodule
